>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the median filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RWMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define RWMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/rwmf_pkg.sv
// ----------------------------------------------------------------------------
// rwmf_pkg
// Types, constants and helpers of the RGB window median filter.
// ----------------------------------------------------------------------------
package rwmf_pkg;

  // Window geometry.
  localparam int KERNEL    = 5;
  localparam int EDGE      = KERNEL / 2;
  localparam int SIDE      = 2 * EDGE + 1;
  localparam int TAPS      = SIDE * SIDE;
  localparam int HALF      = TAPS / 2;
  localparam int RANK_W    = $clog2(TAPS + 1);

  // Frame limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int W_EFF_W    = COL_W + 1;
  localparam int H_EFF_W    = ROW_W + 1;
  localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // Register fields.
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int RESET_WIDTH  = 768;
  localparam int RESET_HEIGHT = 512;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Pixel words.
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W  = CH_W * NUM_CH;

  // Line store: one bank per row modulo NUM_BANKS, one copy per column read.
  localparam int NUM_BANKS = 2 ** $clog2(3 * EDGE + 2);
  localparam int BANK_W    = $clog2(NUM_BANKS);
  localparam int NUM_READS = EDGE + 1;

  // Queues.
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int OF_DEPTH  = 8;
  localparam int OF_PTR_W  = $clog2(OF_DEPTH);
  localparam int OF_CNT_W  = $clog2(OF_DEPTH + 4);

  typedef logic [PIX_W-1:0] pixel_t;

  // Line store write from the front part.
  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    logic [COL_W-1:0]  addr;
    pixel_t            data;
  } wr_t;

  // Effective frame size.
  typedef struct packed {
    logic [W_EFF_W-1:0] w_eff;
    logic [H_EFF_W-1:0] h_eff;
  } geom_t;

  // One output to produce.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } out_word_t;

  // Width as used: zero acts as one, large values saturate.
  function automatic logic [W_EFF_W-1:0] eff_width(input logic [WIDTH_W-1:0] v);
    logic [W_EFF_W-1:0] r;
    if (v == '0) r = W_EFF_W'(1);
    else if (32'(v) > MAX_WIDTH) r = W_EFF_W'(MAX_WIDTH);
    else r = W_EFF_W'(v);
    return r;
  endfunction

  // Height as used: zero acts as one, large values saturate.
  function automatic logic [H_EFF_W-1:0] eff_height(input logic [HEIGHT_W-1:0] v);
    logic [H_EFF_W-1:0] r;
    if (v == '0) r = H_EFF_W'(1);
    else if (32'(v) > MAX_HEIGHT) r = H_EFF_W'(MAX_HEIGHT);
    else r = H_EFF_W'(v);
    return r;
  endfunction

endpackage

>>> hw/rtl/rgb_window_median_filter_top.sv
// ----------------------------------------------------------------------------
// rgb_window_median_filter_top
// Streaming 5x5 per-channel median filter for raster-order RGB pixels.
//
// Input words enter through push/full: command selects a pixel or a flush
// tick. Result words leave through empty/pop in input order, one per pixel,
// frame_last marking the final pixel of a frame. The first result of a frame
// is triggered by the input word that comes 2*width+2 pixels later; flush
// words after the last pixel release the remaining results, one each.
// A triggering word's command passes stages s1 to s3 into the output queue.
// In steady state one word is accepted and one result delivered per cycle
// while pop is held; three column reads per cycle from the banks set it.
// Registers image_width (index 0) and image_height (index 1) are written
// through cfg_valid/cfg_ready, always ready; a write restarts the frame.
// Reset clears all counters and queues and loads 768 x 512; the line store
// needs no clearing. When the receiver stalls, results collect in an 8-word
// output queue; the command queue then fills and full rises. The first pixel
// of a new frame also waits while the previous frame's last command is still
// queued and not leaving.
// ----------------------------------------------------------------------------
module rgb_window_median_filter_top import rwmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  command,
  input  logic [CH_W-1:0]       red,
  input  logic [CH_W-1:0]       green,
  input  logic [CH_W-1:0]       blue,
  output logic                  empty,
  input  logic                  pop,
  output logic [CH_W-1:0]       median_red,
  output logic [CH_W-1:0]       median_green,
  output logic [CH_W-1:0]       median_blue,
  output logic                  frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  wr_t   wr;
  geom_t geom;
  logic  q_push, q_full, q_pop, q_valid;
  cmd_t  q_cmd, q_head;

  // Front part: accept, count and store pixels.
  rwmf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .wr          (wr),
    .geom        (geom),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .q_full      (q_full),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_head_last (q_head.last)
  );

  // Command queue between the two parts.
  rwmf_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  // Back part: window reads, median and output queue.
  rwmf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .geom         (geom),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .median_red   (median_red),
    .median_green (median_green),
    .median_blue  (median_blue),
    .frame_last   (frame_last)
  );

endmodule

>>> hw/rtl/rwmf_ram.sv
// ----------------------------------------------------------------------------
// rwmf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rwmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rwmf_cmd_queue.sv
// ----------------------------------------------------------------------------
// rwmf_cmd_queue
// Short queue of output commands between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwmf_cmd_queue import rwmf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_push,
  input  cmd_t q_cmd,
  output logic q_full,
  input  logic q_pop,
  output logic q_valid,
  output cmd_t q_head
);

  cmd_t               ent [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign q_full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_head  = ent[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_push) begin
      ent[wr_ptr] <= q_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);
    end
  end

  `RWMF_ASSERT(a_q_no_overrun, (!q_push || !q_full) && (!q_pop || q_valid),
    "command queue overrun or underrun")

endmodule

>>> hw/rtl/rwmf_front.sv
// ----------------------------------------------------------------------------
// rwmf_front
// Accepts pixel and flush words, writes pixels to the line store, keeps the
// frame counters and decides which words produce an output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwmf_front import rwmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  command,
  input  logic [CH_W-1:0]       red,
  input  logic [CH_W-1:0]       green,
  input  logic [CH_W-1:0]       blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output wr_t                   wr,
  output geom_t                 geom,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  input  logic                  q_full,
  input  logic                  q_valid,
  input  logic                  q_pop,
  input  logic                  q_head_last
);

  logic [W_EFF_W-1:0] w_eff, w_next;
  logic [H_EFF_W-1:0] h_eff, h_next;
  logic [CNT_W-1:0]   total, total_m1, delay;
  logic [CNT_W-1:0]   w_ext, h_ext, total_next, delay_next;
  logic [CNT_W-1:0]   item_count, out_lin, lag;
  logic [COL_W-1:0]   in_col, out_col;
  logic [ROW_W-1:0]   in_row, out_row;
  logic               cfg_we, cfg_hit;
  logic               accept, pix_take, emit_pix, emit_flush, emit, last;
  logic               in_wrap, out_wrap, frame_hold;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign geom      = '{w_eff: w_eff, h_eff: h_eff};

  // Register decode and derived frame sizes.
  always_comb begin
    w_next  = w_eff;
    h_next  = h_eff;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          w_next  = eff_width(cfg_data[WIDTH_W-1:0]);
          cfg_hit = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          h_next  = eff_height(cfg_data[HEIGHT_W-1:0]);
          cfg_hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
    w_ext      = CNT_W'(w_next);
    h_ext      = CNT_W'(h_next);
    total_next = w_ext * h_ext;
    delay_next = CNT_W'(EDGE) * w_ext + CNT_W'(EDGE);
  end

  // The first pixel of a frame would overwrite rows that commands of the
  // previous frame still have to read, so it waits until the previous frame's
  // last command leaves the queue.
  assign frame_hold = (item_count == '0) && q_valid && !(q_pop && q_head_last);

  // Classification of the incoming word.
  assign full       = q_full || frame_hold;
  assign accept     = push && !full;
  assign lag        = item_count - out_lin;
  assign pix_take   = accept && (command == CMD_PIXEL) && (item_count < total);
  assign emit_pix   = pix_take && (lag >= delay);
  assign emit_flush = accept && (command == CMD_FLUSH) && (item_count == total)
                      && (out_lin < total);
  assign emit       = emit_pix || emit_flush;
  assign last       = (out_lin == total_m1);
  assign in_wrap    = ((W_EFF_W'(in_col) + W_EFF_W'(1)) == w_eff);
  assign out_wrap   = ((W_EFF_W'(out_col) + W_EFF_W'(1)) == w_eff);

  // Line store write and command to the back part.
  assign wr     = '{en: pix_take, bank: in_row[BANK_W-1:0], addr: in_col,
                    data: {red, green, blue}};
  assign q_push = emit;
  assign q_cmd  = '{row: out_row, col: out_col, last: last};

  // Frame registers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff      <= W_EFF_W'(RESET_WIDTH);
      h_eff      <= H_EFF_W'(RESET_HEIGHT);
      total      <= CNT_W'(RESET_WIDTH * RESET_HEIGHT);
      total_m1   <= CNT_W'(RESET_WIDTH * RESET_HEIGHT - 1);
      delay      <= CNT_W'(EDGE * RESET_WIDTH + EDGE);
      item_count <= '0;
      out_lin    <= '0;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (cfg_hit) begin
      w_eff      <= w_next;
      h_eff      <= h_next;
      total      <= total_next;
      total_m1   <= total_next - CNT_W'(1);
      delay      <= delay_next;
      item_count <= '0;
      out_lin    <= '0;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else begin
      if (pix_take) begin
        item_count <= item_count + CNT_W'(1);
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (emit) begin
        if (last) begin
          // Frame done: the next pixel opens a new frame.
          item_count <= '0;
          out_lin    <= '0;
          in_col     <= '0;
          in_row     <= '0;
          out_col    <= '0;
          out_row    <= '0;
        end else begin
          out_lin <= out_lin + CNT_W'(1);
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  `RWMF_ASSERT(a_out_behind_in, out_lin <= item_count,
    "output position ran ahead of input count")

endmodule

>>> hw/rtl/rwmf_back.sv
// ----------------------------------------------------------------------------
// rwmf_back
// Reads window columns from the banked line store, assembles the window,
// ranks every sample per channel and queues the median words for output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwmf_back import rwmf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  wr_t             wr,
  input  geom_t           geom,
  input  logic            q_valid,
  input  cmd_t            q_head,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [CH_W-1:0] median_red,
  output logic [CH_W-1:0] median_green,
  output logic [CH_W-1:0] median_blue,
  output logic            frame_last
);

  logic [COL_W-1:0]  rd_addr [NUM_READS];
  logic [BANK_W-1:0] bank_s0 [SIDE];
  pixel_t            rdata   [NUM_READS][NUM_BANKS];

  logic              s1_valid, s1_first, s1_last;
  logic [BANK_W-1:0] s1_bank [SIDE];
  pixel_t            xcol    [NUM_READS][SIDE];
  pixel_t            hist    [EDGE][SIDE];
  pixel_t            tap     [TAPS];
  logic [TAPS-1:0]   lt_c    [NUM_CH][TAPS];

  logic              s2_valid, s2_last;
  pixel_t            s2_tap  [TAPS];
  logic [TAPS-1:0]   s2_lt   [NUM_CH][TAPS];
  logic [TAPS-1:0]   sel_c   [NUM_CH];

  logic              s3_valid, s3_last;
  pixel_t            s3_tap  [TAPS];
  logic [TAPS-1:0]   s3_sel  [NUM_CH];
  logic [CH_W-1:0]   med     [NUM_CH];

  out_word_t            of_mem [OF_DEPTH];
  logic [OF_PTR_W-1:0]  of_wr_ptr, of_rd_ptr;
  logic [OF_CNT_W-1:0]  of_count, of_credit;
  logic                 of_pop;
  out_word_t            of_head;

  // Issue: take a command while the output queue has room for it.
  assign of_credit = of_count + OF_CNT_W'(s1_valid) + OF_CNT_W'(s2_valid)
                     + OF_CNT_W'(s3_valid);
  assign q_pop     = q_valid && (of_credit < OF_CNT_W'(OF_DEPTH));

  // Column addresses and row banks, clamped to the frame.
  always_comb begin
    logic [COL_W:0] c_ext;
    logic [ROW_W:0] r_ext;
    for (int k = 0; k < NUM_READS; k++) begin
      c_ext = {1'b0, q_head.col} + (COL_W+1)'(k);
      if (c_ext >= geom.w_eff) c_ext = geom.w_eff - W_EFF_W'(1);
      rd_addr[k] = c_ext[COL_W-1:0];
    end
    for (int d = 0; d < SIDE; d++) begin
      r_ext = {1'b0, q_head.row} + (ROW_W+1)'(d);
      if (r_ext < (ROW_W+1)'(EDGE)) begin
        r_ext = '0;
      end else begin
        r_ext = r_ext - (ROW_W+1)'(EDGE);
        if (r_ext >= geom.h_eff) r_ext = geom.h_eff - H_EFF_W'(1);
      end
      bank_s0[d] = r_ext[BANK_W-1:0];
    end
  end

  // Line store: one bank per row residue, one copy per column read.
  for (genvar k = 0; k < NUM_READS; k++) begin : g_read
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      rwmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
        .clk   (clk),
        .we    (wr.en && (wr.bank == BANK_W'(b))),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr[k]),
        .rdata (rdata[k][b])
      );
    end
  end

  // Window assembly: new columns from the store, older ones from history.
  always_comb begin
    for (int k = 0; k < NUM_READS; k++) begin
      for (int d = 0; d < SIDE; d++) begin
        xcol[k][d] = rdata[k][s1_bank[d]];
      end
    end
    for (int m = 0; m < SIDE; m++) begin
      for (int d = 0; d < SIDE; d++) begin
        if (m >= EDGE) tap[m*SIDE+d] = xcol[m-EDGE][d];
        else if (s1_first) tap[m*SIDE+d] = xcol[0][d];
        else tap[m*SIDE+d] = hist[EDGE-1-m][d];
      end
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int i = 0; i < TAPS; i++) begin
        for (int j = 0; j < TAPS; j++) begin
          lt_c[ch][i][j] = tap[i][PIX_W-1-CH_W*ch -: CH_W]
                           < tap[j][PIX_W-1-CH_W*ch -: CH_W];
        end
      end
    end
  end

  // Rank test: a sample is the median when at most HALF lie on either side.
  always_comb begin
    logic [RANK_W-1:0] n_lt;
    logic [RANK_W-1:0] n_gt;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int i = 0; i < TAPS; i++) begin
        n_lt = '0;
        n_gt = '0;
        for (int j = 0; j < TAPS; j++) begin
          n_lt = n_lt + RANK_W'(s2_lt[ch][j][i]);
          n_gt = n_gt + RANK_W'(s2_lt[ch][i][j]);
        end
        sel_c[ch][i] = (n_lt <= RANK_W'(HALF)) && (n_gt <= RANK_W'(HALF));
      end
    end
  end

  // Median pick: every selected sample holds the same value.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      med[ch] = '0;
      for (int i = 0; i < TAPS; i++) begin
        med[ch] = med[ch] | (s3_tap[i][PIX_W-1-CH_W*ch -: CH_W] & {CH_W{s3_sel[ch][i]}});
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_bank  <= bank_s0;
      s1_first <= (q_head.col == '0);
      s1_last  <= q_head.last;
    end
    if (s1_valid) begin
      for (int d = 0; d < SIDE; d++) begin
        hist[0][d] <= xcol[0][d];
        for (int j = 1; j < EDGE; j++) begin
          hist[j][d] <= s1_first ? xcol[0][d] : hist[j-1][d];
        end
      end
      s2_tap  <= tap;
      s2_lt   <= lt_c;
      s2_last <= s1_last;
    end
    if (s2_valid) begin
      s3_tap  <= s2_tap;
      s3_sel  <= sel_c;
      s3_last <= s2_last;
    end
    if (s3_valid) begin
      of_mem[of_wr_ptr] <= '{red: med[0], green: med[1], blue: med[2], last: s3_last};
    end
  end

  // Pipeline valids and output queue pointers.
  assign of_pop = pop && !empty;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      of_wr_ptr <= '0;
      of_rd_ptr <= '0;
      of_count  <= '0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (s3_valid) of_wr_ptr <= of_wr_ptr + 1'b1;
      if (of_pop)   of_rd_ptr <= of_rd_ptr + 1'b1;
      of_count <= of_count + OF_CNT_W'(s3_valid) - OF_CNT_W'(of_pop);
    end
  end

  // Result ports show the oldest waiting word.
  assign empty        = (of_count == '0);
  assign of_head      = of_mem[of_rd_ptr];
  assign median_red   = of_head.red;
  assign median_green = of_head.green;
  assign median_blue  = of_head.blue;
  assign frame_last   = of_head.last;

  `RWMF_ASSERT(a_of_bound, of_count <= OF_CNT_W'(OF_DEPTH),
    "output queue fill level out of range")
  `RWMF_ASSERT(a_of_room, s3_valid |-> (of_count < OF_CNT_W'(OF_DEPTH)),
    "median word arrived with no room reserved")

endmodule

>>> dv/tb_rgb_window_median_filter_top.sv
// ----------------------------------------------------------------------------
// tb_rgb_window_median_filter_top
// Self-checking bench for the streaming 5x5 RGB median filter. A scoreboard
// class keeps its own line history, frame counters and register copies. From
// these it predicts every result word, and it checks each word popped from
// the block in order. Frames of many sizes are streamed with random gaps on
// both sides, with ignored commands mixed in and some frames abandoned.
// ----------------------------------------------------------------------------
module tb_rgb_window_median_filter_top;
  import rwmf_pkg::*;

  localparam int HIST_DEPTH = KERNEL * MAX_WIDTH;
  localparam int WD_LIMIT   = 2000;
  localparam int SETTLE     = 16;

  // Scoreboard: predicts median words from accepted inputs and checks results.
  class median_scoreboard;
    pixel_t                line_hist[HIST_DEPTH];
    int unsigned           out_col, out_row, pix_count;
    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    out_word_t             expected_q[$];
    int                    mismatches, results_seen;

    function new();
      foreach (line_hist[i]) line_hist[i] = '0;
      width_reg  = WIDTH_W'(RESET_WIDTH);
      height_reg = HEIGHT_W'(RESET_HEIGHT);
      clear_counters();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void clear_counters();
      out_col   = 0;
      out_row   = 0;
      pix_count = 0;
    endfunction

    function int unsigned cur_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned cur_h();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = d[WIDTH_W-1:0];
        clear_counters();
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = d[HEIGHT_W-1:0];
        clear_counters();
      end
    endfunction

    // All pixels of the frame are in and results are still owed.
    function bit frame_draining();
      int unsigned total;
      total = cur_w() * cur_h();
      return pix_count == total && out_row * cur_w() + out_col < total;
    endfunction

    function int unsigned clamp(int v, int unsigned lim);
      if (v < 0) return 0;
      if (v >= int'(lim)) return lim - 1;
      return v;
    endfunction

    // Median of one channel over the window gathered in taps.
    function logic [CH_W-1:0] channel_median(pixel_t taps[TAPS], int shift);
      int vals[TAPS];
      int i, j, v;
      for (i = 0; i < TAPS; i++) vals[i] = (taps[i] >> shift) & 8'hff;
      for (i = 1; i < TAPS; i++) begin
        v = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > v) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = v;
      end
      return CH_W'(vals[HALF]);
    endfunction

    // Build the expected word for the current output position and advance.
    function void produce_word();
      pixel_t      taps[TAPS];
      out_word_t   w;
      int unsigned wd, ht, total, k, ry, rx;
      wd    = cur_w();
      ht    = cur_h();
      total = wd * ht;
      k     = out_row * wd + out_col;
      for (int dy = 0; dy < SIDE; dy++) begin
        ry = clamp(int'(out_row) + dy - EDGE, ht);
        for (int dx = 0; dx < SIDE; dx++) begin
          rx = clamp(int'(out_col) + dx - EDGE, wd);
          taps[dy*SIDE+dx] = line_hist[(ry * wd + rx) % HIST_DEPTH];
        end
      end
      w.red   = channel_median(taps, 16);
      w.green = channel_median(taps, 8);
      w.blue  = channel_median(taps, 0);
      w.last  = (k == total - 1);
      expected_q.push_back(w);
      if (k == total - 1) begin
        clear_counters();
      end else begin
        out_col++;
        if (out_col >= wd) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    // Note one accepted input word.
    function void note_input(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b);
      int unsigned wd, total, lag;
      wd    = cur_w();
      total = wd * cur_h();
      lag   = EDGE * wd + EDGE;
      if (cmd == CMD_PIXEL) begin
        if (pix_count >= total) return;
        line_hist[pix_count % HIST_DEPTH] = {r, g, b};
        pix_count++;
        if (pix_count - 1 >= out_row * wd + out_col + lag) produce_word();
      end else if (frame_draining()) begin
        produce_word();
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one popped result word with the oldest expectation.
    task check_result(out_word_t got);
      out_word_t exp_w;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word r=%0d g=%0d b=%0d last=%0d",
                         got.red, got.green, got.blue, got.last));
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.red !== exp_w.red)
        report($sformatf("word %0d red %0d, expected %0d", results_seen, got.red, exp_w.red));
      if (got.green !== exp_w.green)
        report($sformatf("word %0d green %0d, expected %0d", results_seen, got.green,
                         exp_w.green));
      if (got.blue !== exp_w.blue)
        report($sformatf("word %0d blue %0d, expected %0d", results_seen, got.blue,
                         exp_w.blue));
      if (got.last !== exp_w.last)
        report($sformatf("word %0d frame_last %0d, expected %0d", results_seen, got.last,
                         exp_w.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  logic                  command;
  logic [CH_W-1:0]       red, green, blue;
  logic                  empty;
  logic                  pop;
  logic [CH_W-1:0]       median_red, median_green, median_blue;
  logic                  frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  median_scoreboard sb;
  int  words_sent;
  int  frames_run;
  int  reg_writes;
  int  idle_cycles;
  int  pop_hold;
  bit  quiet;

  rgb_window_median_filter_top DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .red(red), .green(green), .blue(blue), .empty(empty), .pop(pop),
    .median_red(median_red), .median_green(median_green),
    .median_blue(median_blue), .frame_last(frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: pops with random stall bursts and checks every popped word.
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty)
        sb.check_result('{red: median_red, green: median_green, blue: median_blue,
                          last: frame_last});
      if (pop_hold > 0) begin
        pop_hold <= pop_hold - 1;
        pop      <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        pop_hold <= $urandom_range(0, 14);
        pop      <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted word of any kind.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("tb_rgb_window_median_filter_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function logic [CH_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  // Send one input word, with an occasional gap before it.
  task send_word(logic cmd);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push    <= 1'b1;
    command <= cmd;
    red     <= rand_sample();
    green   <= rand_sample();
    blue    <= rand_sample();
    do @(posedge clk); while (full);
    sb.note_input(command, red, green, blue);
    words_sent++;
  endtask

  // Hold the sender until every expected word has come back.
  task drain_all();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task set_size(int unsigned wd, int unsigned ht);
    drain_all();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wd));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(ht));
  endtask

  // Stream n pixels, then flush the frame out. Noise adds ignored words.
  task run_frame(int n, bit noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) send_word(CMD_FLUSH);
      send_word(CMD_PIXEL);
    end
    while (sb.frame_draining()) begin
      if (noisy && $urandom_range(0, 14) == 0) send_word(CMD_PIXEL);
      send_word(CMD_FLUSH);
    end
    frames_run++;
  endtask

  initial begin
    int unsigned wd, ht;
    sb          = new();
    rst         = 1'b1;
    push        = 1'b0;
    command     = CMD_PIXEL;
    red         = '0;
    green       = '0;
    blue        = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_IMAGE_WIDTH;
    cfg_data    = '0;
    idle_cycles = 0;
    words_sent  = 0;
    frames_run  = 0;
    reg_writes  = 0;
    quiet       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: early flush, extra pixel and flush around a 3x2 frame.
    set_size(3, 2);
    send_word(CMD_FLUSH);
    for (int i = 0; i < 6; i++) send_word(CMD_PIXEL);
    send_word(CMD_PIXEL);
    while (sb.frame_draining()) send_word(CMD_FLUSH);
    send_word(CMD_FLUSH);
    frames_run++;

    // Zero sizes act as a single pixel.
    set_size(0, 0);
    run_frame(1, 1'b0);

    // Oversized registers saturate; the frame is abandoned part way.
    set_size(2047, 8191);
    for (int i = 0; i < 8; i++) send_word(CMD_PIXEL);
    set_size(MAX_WIDTH, MAX_HEIGHT);
    for (int i = 0; i < 4; i++) send_word(CMD_PIXEL);
    set_size($urandom_range(1, 12), $urandom_range(1, 8));

    // Random frames, mostly small and well formed.
    while (words_sent < 1550) begin
      if (words_sent > 1300) quiet = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        wd = $urandom_range(0, 1) ? $urandom_range(1025, 2047) : $urandom_range(0, 1024);
        ht = $urandom_range(0, 8191);
        set_size(wd, ht);
        for (int i = 0; i < $urandom_range(1, 30); i++) send_word(CMD_PIXEL);
        set_size($urandom_range(1, 12), $urandom_range(1, 8));
      end else if ($urandom_range(0, 9) < 7) begin
        set_size($urandom_range(1, 12), $urandom_range(1, 8));
      end else if ($urandom_range(0, 5) == 0) begin
        drain_all();
      end
      run_frame(sb.cur_w() * sb.cur_h() - sb.pix_count, $urandom_range(0, 3) == 0);
    end

    drain_all();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.expected_q.size()));
    $display("Streamed %0d words over %0d frames with %0d register writes,",
             words_sent, frames_run, reg_writes);
    $display("and checked %0d median words.", sb.results_seen);
    if (sb.mismatches == 0) begin
      $display("tb_rgb_window_median_filter_top passed");
    end else begin
      $display("tb_rgb_window_median_filter_top failed");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rwmf_pkg.sv
hw/rtl/rwmf_ram.sv
hw/rtl/rwmf_cmd_queue.sv
hw/rtl/rwmf_front.sv
hw/rtl/rwmf_back.sv
hw/rtl/rgb_window_median_filter_top.sv
dv/tb_rgb_window_median_filter_top.sv
